// File: design/uwbps_pkg.sv
package uwbps_pkg;

	localparam int DATA_W = 8;
	localparam int ADDR_W = 48;
	localparam int SIG_BYTES = 16;
	localparam int CFG_W = 64;
	localparam int CFG_IDX_W = 2;
	localparam int LEN_W = 5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd3;

	// match status codes, also used for the saturating match count
	localparam logic [1:0] STATUS_NONE = 2'd0;
	localparam logic [1:0] STATUS_UNIQUE = 2'd1;
	localparam logic [1:0] STATUS_AMBIGUOUS = 2'd2;

	typedef struct packed {
		logic [DATA_W-1:0] data_byte;
		logic [ADDR_W-1:0] byte_address;
		logic              range_first;
		logic              scan_last;
	} item_t;

	typedef struct packed {
		logic [1:0]        match_status;
		logic [ADDR_W-1:0] match_address;
	} result_t;

	typedef struct packed {
		logic [SIG_BYTES-1:0][DATA_W-1:0] pattern;
		logic [SIG_BYTES-1:0]             care;
		logic [LEN_W-1:0]                 length;
	} sig_cfg_t;

endpackage

// File: design/uwbps_match.sv
module uwbps_match
	import uwbps_pkg::*;
#(
	parameter int MAX_PATTERN = 16
) (
	input  sig_cfg_t                                  cfg,
	input  logic [DATA_W-1:0]                         cur_byte,
	input  logic [MAX_PATTERN-2:0][DATA_W-1:0]        window,
	input  logic [$clog2(MAX_PATTERN)-1:0]            fill,
	output logic                                      hit
);

	localparam int IW = 6;

	logic [MAX_PATTERN-1:0][DATA_W-1:0] bytes_all;
	logic [MAX_PATTERN-1:0]             pos_ok;
	logic                               len_ok;
	logic                               fill_ok;

	// bytes_all[j] is the byte j positions back from the newest one
	assign bytes_all = {window, cur_byte};

	// window position j lines up with pattern byte length-1-j
	always_comb begin
		logic [IW-1:0] idx;
		logic          cares;
		for (int j = 0; j < MAX_PATTERN; j++) begin
			idx = IW'(cfg.length) - IW'(j) - IW'(1);
			cares = (IW'(j) < IW'(cfg.length)) && (idx < IW'(SIG_BYTES))
				&& cfg.care[idx[3:0]];
			pos_ok[j] = !cares || (bytes_all[j] == cfg.pattern[idx[3:0]]);
		end
	end

	assign len_ok = (cfg.length != '0) && (IW'(cfg.length) <= IW'(MAX_PATTERN));
	assign fill_ok = (IW'(fill) + IW'(1)) >= IW'(cfg.length);
	assign hit = len_ok && fill_ok && (&pos_ok);

endmodule

// File: design/unique_wildcard_byte_pattern_scan_top.sv
// wildcard byte signature scanner
// item channel (item_valid / item_stall / item): one memory byte per word with
// its address, a range_first flag that restarts the match window and a
// scan_last flag that closes the scan.
// result channel (result_valid / result_stall / result): one word per scan,
// given for the word carrying scan_last: status none, unique or ambiguous, and
// the start address of the match when it is unique (zero otherwise).
// config port (cfg_wr_en / cfg_index / cfg_data): pattern bytes low and high,
// care mask and pattern length, written while the scanner is idle.
// an accepted word is held in the input register and compared from there; a
// scan-ending word then writes the result register, unless a shown result stalls.
// throughput is one word per cycle while item_stall is low, set by the
// combinational window compare between the input and result registers.
// reset clears configuration, match count, window fill and both valid flags.
// a stalled result holds; the input register keeps taking plain bytes and only
// a scan-ending word waiting behind a stalled result raises item_stall.
module unique_wildcard_byte_pattern_scan_top
	import uwbps_pkg::*;
#(
	parameter int MAX_PATTERN = 16,
	parameter int ADDRESS_BITS = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int WIN = MAX_PATTERN - 1;
	localparam int FW = $clog2(MAX_PATTERN);
	// effective address width: the result field is 48 bits wide
	localparam int EAW = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;

	sig_cfg_t                     cfg_q;
	logic                         valid_s1;
	item_t                        item_s1;
	logic [WIN-1:0][DATA_W-1:0]   win_q;
	logic [FW-1:0]                fill_q;
	logic [1:0]                   count_q;
	logic [EAW-1:0]               first_q;

	logic                         advance;
	logic                         res_free;
	logic                         hit;
	logic [FW-1:0]                fill_eff;
	logic [1:0]                   count_d;
	logic [EAW-1:0]               first_d;
	logic [EAW-1:0]               start_addr;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_PATTERN_LOW:    cfg_q.pattern[7:0] <= cfg_data;
				CFG_PATTERN_HIGH:   cfg_q.pattern[15:8] <= cfg_data;
				CFG_CARE_MASK:      cfg_q.care <= cfg_data[SIG_BYTES-1:0];
				CFG_PATTERN_LENGTH: cfg_q.length <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// the input register moves on unless it holds a scan end that cannot
	// yet be written into a still stalled result register
	assign res_free = !result_valid || !result_stall;
	assign advance = valid_s1 && (!item_s1.scan_last || res_free);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// a new range starts with an empty window
	assign fill_eff = item_s1.range_first ? '0 : fill_q;

	uwbps_match #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_match (
		.cfg(cfg_q),
		.cur_byte(item_s1.data_byte),
		.window(win_q),
		.fill(fill_eff),
		.hit(hit)
	);

	// match start: byte address minus length-1, wrapping in the address width
	assign start_addr = item_s1.byte_address[EAW-1:0]
		- EAW'(cfg_q.length - LEN_W'(1));

	always_comb begin
		count_d = count_q;
		first_d = first_q;
		if (hit) begin
			if (count_q == STATUS_NONE) begin
				first_d = start_addr;
			end
			if (count_q != STATUS_AMBIGUOUS) begin
				count_d = count_q + 2'd1;
			end
		end
	end

	// scan state; bytes past the fill count are never compared, so the
	// window itself needs no clearing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			count_q <= STATUS_NONE;
			first_q <= '0;
		end else if (advance) begin
			if (item_s1.scan_last) begin
				fill_q <= '0;
				count_q <= STATUS_NONE;
				first_q <= '0;
			end else begin
				fill_q <= (fill_eff < FW'(WIN)) ? fill_eff + FW'(1) : fill_eff;
				count_q <= count_d;
				first_q <= first_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			win_q <= {win_q[WIN-2:0], item_s1.data_byte};
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance && item_s1.scan_last) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.scan_last) begin
			result.match_status <= count_d;
			result.match_address <= (count_d == STATUS_UNIQUE) ? ADDR_W'(first_d) : '0;
		end
	end

	// match count saturates at the ambiguous code
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("match count out of range");

	// a shown result only carries an address when it is unique
	a_addr_unique: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.match_status != STATUS_UNIQUE)
		|-> result.match_address == '0)
		else $error("address given for non-unique result");

	// input only stalls behind a scan end waiting on a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && item_s1.scan_last && result_valid && result_stall)
		else $error("input stalled without cause");

	// a scan end leaves clean scan state and a pending result
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.scan_last
		|=> result_valid && (count_q == STATUS_NONE) && (fill_q == '0))
		else $error("scan state not cleared at scan end");

endmodule

// File: dv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import uwbps_pkg::*;

	// run limit, far above the slowest legal run
	localparam int LIMIT = 1_000_000;
	// words per random phase
	localparam int PHASE_WORDS = 100;

	// shape of one run of bytes inside a scan
	typedef enum {RUN_FILLER, RUN_SIGNATURE, RUN_BROKEN} run_kind_t;

	// predicts the scan verdicts and holds them until the block reports them
	class scan_verdict_board;
		logic [DATA_W-1:0]    sig [SIG_BYTES];
		logic [SIG_BYTES-1:0] care;
		logic [LEN_W-1:0]     sig_len;
		logic [DATA_W-1:0]    history [SIG_BYTES-1];
		int                   fill;
		int                   hits;
		logic [ADDR_W-1:0]    first_hit;
		result_t              awaited [$];
		int                   errors;

		function new();
			foreach (sig[i]) sig[i] = '0;
			care = '0;
			sig_len = '0;
			errors = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			foreach (history[i]) history[i] = '0;
			fill = 0;
			hits = 0;
			first_hit = '0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
			case (idx)
				CFG_PATTERN_LOW: for (int i = 0; i < 8; i++) sig[i] = d[8*i +: 8];
				CFG_PATTERN_HIGH: for (int i = 0; i < 8; i++) sig[i+8] = d[8*i +: 8];
				CFG_CARE_MASK: care = d[SIG_BYTES-1:0];
				CFG_PATTERN_LENGTH: sig_len = d[LEN_W-1:0];
				default: ;
			endcase
		endfunction

		// does the window ending in cur hold the signature
		function bit signature_hit(logic [DATA_W-1:0] cur);
			int n;
			int back;
			logic [DATA_W-1:0] b;
			n = sig_len;
			if (n == 0 || n > SIG_BYTES) return 1'b0;
			if (fill < n - 1) return 1'b0;
			for (int i = 0; i < n; i++) begin
				back = n - 1 - i;
				b = (back == 0) ? cur : history[back-1];
				if (care[i] && b != sig[i]) return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_byte(item_t w);
			result_t v;
			if (w.range_first) begin
				foreach (history[i]) history[i] = '0;
				fill = 0;
			end
			if (signature_hit(w.data_byte)) begin
				if (hits == 0) first_hit = w.byte_address - ADDR_W'(sig_len) + 1'b1;
				if (hits < 2) hits++;
			end
			for (int k = SIG_BYTES - 2; k > 0; k--) history[k] = history[k-1];
			history[0] = w.data_byte;
			if (fill < SIG_BYTES - 1) fill++;
			if (w.scan_last) begin
				v.match_status = (hits == 0) ? STATUS_NONE :
					(hits == 1) ? STATUS_UNIQUE : STATUS_AMBIGUOUS;
				v.match_address = (hits == 1) ? first_hit : '0;
				awaited = {awaited, v};
				clear_scan();
			end
		endfunction

		function void check_verdict(result_t r);
			result_t x;
			if (awaited.size() == 0) begin
				$error("match_status: expected nothing, got %0d", r.match_status);
				errors++;
				return;
			end
			x = awaited.pop_front();
			if (r.match_status !== x.match_status) begin
				$error("match_status: expected %0d, got %0d", x.match_status, r.match_status);
				errors++;
			end
			if (r.match_address !== x.match_address) begin
				$error("match_address: expected %h, got %h", x.match_address, r.match_address);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_stall;
	item_t                item;
	logic                 result_valid;
	logic                 result_stall;
	result_t              result;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	scan_verdict_board board = new();
	bit                calm = 1'b0;      // phase without gaps or stalls
	int                sent = 0;         // words accepted by the block
	int                cycles = 0;
	logic [ADDR_W-1:0] next_addr = '0;   // address of the next byte in the range

	unique_wildcard_byte_pattern_scan_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("unique_wildcard_byte_pattern_scan_top regression: fail");
			$finish;
		end
	end

	// monitors: everything is sampled at the rising edge, before the block updates
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) board.note_byte(item);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) board.check_verdict(result);
	end

	always @(posedge clk) begin
		if (arst_n && cfg_wr_en) board.write_reg(cfg_index, cfg_data);
	end

	// mostly short gaps, now and then a long one, none in a calm phase
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// start of a new range: mostly anywhere, sometimes near either end of memory
	function automatic logic [ADDR_W-1:0] pick_base();
		logic [63:0] t;
		int r;
		t = {$urandom, $urandom};
		r = $urandom_range(0, 9);
		if (r == 0) return {ADDR_W{1'b1}} - ADDR_W'($urandom_range(0, 20));
		if (r == 1) return ADDR_W'($urandom_range(0, 20));
		return t[ADDR_W-1:0];
	endfunction

	// result side back-pressure
	initial begin
		int n;
		forever begin
			@(negedge clk);
			n = pick_gap();
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			result_stall <= 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	end

	// one word on the item channel; returns at the edge that accepts it
	task automatic send_word(logic [DATA_W-1:0] d, logic [ADDR_W-1:0] a, bit opens,
			bit closes);
		item_t w;
		int gap;
		w.data_byte = d;
		w.byte_address = a;
		w.range_first = opens;
		w.scan_last = closes;
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sent++;
	endtask

	// stop sending, drain all verdicts, then let the pipeline empty
	task automatic wait_idle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (board.awaited.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic poke_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic configure(input logic [CFG_W-1:0] lo, hi, input logic [SIG_BYTES-1:0] cm,
			input logic [LEN_W-1:0] ln);
		wait_idle();
		poke_reg(CFG_PATTERN_LOW, lo);
		poke_reg(CFG_PATTERN_HIGH, hi);
		poke_reg(CFG_CARE_MASK, CFG_W'(cm));
		poke_reg(CFG_PATTERN_LENGTH, CFG_W'(ln));
	endtask

	// filler bytes, the signature with random wildcard bytes, or the
	// signature with one bit flipped
	task automatic send_run(run_kind_t kind, bit opens, bit closes);
		int n;
		int flip;
		logic [DATA_W-1:0] b;
		n = (board.sig_len > SIG_BYTES) ? SIG_BYTES : int'(board.sig_len);
		if (kind == RUN_FILLER || n == 0) n = $urandom_range(1, 8);
		flip = $urandom_range(0, n - 1);
		for (int i = 0; i < n; i++) begin
			b = DATA_W'($urandom);
			if (kind != RUN_FILLER && i < board.sig_len && board.care[i]) b = board.sig[i];
			if (kind == RUN_BROKEN && i == flip) b ^= DATA_W'(1 << $urandom_range(0, DATA_W - 1));
			send_word(b, next_addr, opens && i == 0, closes && i == n - 1);
			next_addr++;
		end
	endtask

	// one whole scan: up to four runs, the first mostly starting a range, ended by scan_last
	task automatic random_scan();
		int segs;
		int r;
		bit opens;
		bit closes;
		run_kind_t kind;
		segs = $urandom_range(0, 4);
		for (int s = 0; s < segs; s++) begin
			opens = (s == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 4) == 0);
			if (opens) next_addr = pick_base();
			// address jump inside a range now and then
			else if ($urandom_range(0, 19) == 0) next_addr = pick_base();
			closes = (s == segs - 1) && $urandom_range(0, 1);
			r = $urandom_range(0, 9);
			kind = (r < 4) ? RUN_FILLER : (r < 8) ? RUN_SIGNATURE : RUN_BROKEN;
			send_run(kind, opens, closes);
			if (closes) return;
		end
		send_word(DATA_W'($urandom), next_addr, segs == 0 && $urandom_range(0, 1), 1'b1);
		next_addr++;
	endtask

	initial begin
		int ph;
		int goal;
		clk = 1'b0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_PATTERN_LOW;
		cfg_data = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// signature ff 00 ?? 5a, byte 2 a wildcard
		configure(64'h0000_0000_5A77_00FF, {CFG_W{1'b1}}, 16'h000B, 5'd4);
		// one-word scan, nothing found
		send_word(8'h00, 48'h0, 1'b1, 1'b1);
		// unique match that ends on scan_last, its start wraps below address zero
		send_word(8'hFF, 48'hFFFF_FFFF_FFFE, 1'b1, 1'b0);
		send_word(8'h00, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0);
		send_word(8'hFF, 48'h0, 1'b0, 1'b0);
		send_word(8'h5A, 48'h1, 1'b0, 1'b1);
		// signature split by a range start never matches
		send_word(8'hFF, 48'd100, 1'b1, 1'b0);
		send_word(8'h00, 48'd101, 1'b0, 1'b0);
		send_word(8'h00, 48'd102, 1'b1, 1'b0);
		send_word(8'h5A, 48'd103, 1'b0, 1'b0);
		send_word(8'hFF, 48'd104, 1'b0, 1'b1);
		// two matches back to back, ambiguous
		send_word(8'hFF, 48'd200, 1'b1, 1'b0);
		send_word(8'h00, 48'd201, 1'b0, 1'b0);
		send_word(8'h12, 48'd202, 1'b0, 1'b0);
		send_word(8'h5A, 48'd203, 1'b0, 1'b0);
		send_word(8'hFF, 48'd204, 1'b0, 1'b0);
		send_word(8'h00, 48'd205, 1'b0, 1'b0);
		send_word(8'h00, 48'd206, 1'b0, 1'b0);
		send_word(8'h5A, 48'd207, 1'b0, 1'b1);

		// zero length never matches, even with every byte a wildcard
		configure('0, '0, '0, 5'd0);
		next_addr = pick_base();
		send_run(RUN_FILLER, 1'b1, 1'b1);
		// length above the signature size never matches either
		configure('0, '0, '0, 5'd31);
		next_addr = pick_base();
		send_run(RUN_FILLER, 1'b1, 1'b1);

		// random phases, one setting each
		for (ph = 0; ph < 11; ph++) begin
			calm = (ph % 4 == 2);
			case (ph)
				0: configure({$urandom, $urandom}, {$urandom, $urandom}, '1, 5'd16);
				1: configure({$urandom, $urandom}, {$urandom, $urandom},
					SIG_BYTES'($urandom), 5'd1);
				2: configure('1, '1, '0, 5'd16);
				3: configure('0, '0, '1, LEN_W'($urandom_range(2, 15)));
				4: configure('0, '1, SIG_BYTES'($urandom | $urandom), 5'd8);
				10: configure({$urandom, $urandom}, {$urandom, $urandom},
					SIG_BYTES'($urandom | $urandom), LEN_W'($urandom_range(0, 31)));
				default: configure({$urandom, $urandom}, {$urandom, $urandom},
					SIG_BYTES'($urandom | $urandom), LEN_W'($urandom_range(2, 16)));
			endcase
			goal = sent + PHASE_WORDS;
			while (sent < goal) random_scan();
		end

		// drain, then give stray verdicts time to show up
		wait_idle();
		repeat (10) @(posedge clk);
		if (board.errors == 0) begin
			$display("unique_wildcard_byte_pattern_scan_top regression: pass");
		end else begin
			$display("unique_wildcard_byte_pattern_scan_top regression: fail");
		end
		$finish;
	end

endmodule

// File: sim.f
design/uwbps_pkg.sv
design/uwbps_match.sv
design/unique_wildcard_byte_pattern_scan_top.sv
dv/tb_top.sv
